// ----- sv/lav_pkg.sv -----
// Shared constants and types for the look-at view matrix block.
package lav_pkg;

	localparam int unsigned COORD_W   = 32;  // Q16.16 coordinate
	localparam int unsigned UNIT_W    = 32;  // Q2.30 unit component, signed
	localparam int unsigned FRAC_UNIT = 30;  // fraction bits of a unit component
	localparam int unsigned NORM_W    = 31;  // magnitude after scaling into [2^30, 2^31)
	localparam int unsigned ROOT_W    = 32;  // vector length, also quotient width

	localparam logic [UNIT_W-1:0]  UNIT_ONE = 32'h4000_0000;
	localparam logic [COORD_W-1:0] Q_ONE    = 32'h0001_0000;
	localparam logic [1:0]         COL_LAST = 2'd3;

	// status of a normalizer result
	typedef struct packed {
		logic valid;
		logic zero;
	} lav_nstat_t;

endpackage

// ----- sv/look_at_view_matrix.sv -----
// Top level of the look-at view matrix block: stream in, four matrix columns out.
//
// Input channel s_*: one item is eye, center and up, nine signed Q16.16 words,
// taken when s_tvalid and s_tready are both high.
// Output channel m_*: each item yields four results, columns 0 to 3 of the
// column-major view matrix, in order; m_tlast marks column 3 and m_tuser
// carries the degenerate flag (zero forward or side vector, identity matrix).
// The first column shows on m_tvalid once the item has gone through stages 1 to 8,
// both normalizers and the output holding register; the next three follow one per
// cycle while m_tready is high. The single output channel, four columns per item,
// sets the item rate; the pipeline itself takes an item per cycle when not stalled.
// Datapath: two normalizers (forward and side vector), each with a 32-stage
// square root and three 32-stage dividers, then cross products and the
// translation dot products, each multiply followed by a register.
// The whole pipeline moves on one enable; when the output holding register
// still has columns to send and the last stage holds an item, everything
// stalls, s_tready drops, and nothing is lost or repeated.
// Reset clears all valid bits and the output state; no item is in flight.
module look_at_view_matrix
	import lav_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// column_index[1:0], elem_row0, elem_row1, elem_row2, elem_row3, zero pad
	output logic [135:0] m_tdata,
	// degenerate
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int unsigned SIDE_F_W = 6 * COORD_W;
	localparam int unsigned SIDE_S_W = 6 * COORD_W + 1;
	localparam int unsigned DIFF_W   = COORD_W + 1;
	localparam int unsigned PROD_W   = 2 * COORD_W;
	localparam int unsigned DOT_W    = PROD_W + 2;

	logic adv, load, m_take;

	// stage 1: inputs and forward difference
	logic                    v_s1;
	logic [2:0][COORD_W-1:0] eye_s1, up_s1;
	logic [2:0][DIFF_W-1:0]  fd_s1;

	lav_nstat_t              f_stat;
	logic [2:0][UNIT_W-1:0]  f_unit;
	logic [SIDE_F_W-1:0]     f_side;

	// stages 2, 3: side vector f x up
	logic                    v_s2, v_s3, fz_s2, fz_s3;
	logic [5:0][PROD_W-1:0]  fup_s2;
	logic [2:0][PROD_W-1:0]  sr_s3;
	logic [2:0][UNIT_W-1:0]  f_s2, f_s3;
	logic [2:0][COORD_W-1:0] eye_s2, eye_s3;

	lav_nstat_t              s_stat;
	logic [2:0][UNIT_W-1:0]  s_unit;
	logic [SIDE_S_W-1:0]     s_side;

	// stages 4, 5: up vector s x f
	logic                    v_s4, v_s5, dg_s4, dg_s5;
	logic [5:0][PROD_W-1:0]  sf_s4;
	logic [2:0][UNIT_W-1:0]  s_s4, f_s4, s_s5, f_s5, u_s5;
	logic [2:0][COORD_W-1:0] eye_s4, eye_s5;

	// stages 6..8: rotation, translation, matrix
	logic                         v_s6, v_s7, v_s8, dg_s6, dg_s7, dg_s8;
	logic [2:0][2:0][PROD_W-1:0]  prd_s6;
	logic [2:0][2:0][COORD_W-1:0] rq_s6, rq_s7;
	logic [2:0][DOT_W-1:0]        dot_s7;
	logic [3:0][3:0][COORD_W-1:0] mat_s8;

	// output holding register
	logic                         full_q, odg_q;
	logic [1:0]                   col_q;
	logic [3:0][3:0][COORD_W-1:0] om_q;

	logic [2:0][2:0][UNIT_W-1:0]  rot;
	logic [2:0][2:0][COORD_W-1:0] rq_n;
	logic [2:0][UNIT_W-1:0]       u_n;
	logic [2:0][COORD_W-1:0]      tr_n;
	logic [3:0][3:0][COORD_W-1:0] mat_n;
	logic signed [PROD_W-1:0]     ud;
	logic signed [DOT_W-1:0]      nd, rs;
	logic signed [DIFF_W-1:0]     rr;

	assign m_tvalid = full_q;
	assign m_take   = full_q & m_tready;
	assign load     = v_s8 & (~full_q | (m_take & (col_q == COL_LAST)));
	assign adv      = ~v_s8 | load;
	assign s_tready = adv;

	lav_norm #(
		.W      (DIFF_W),
		.SIDE_W (SIDE_F_W)
	) u_norm_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.vec      (fd_s1),
		.side_in  ({up_s1, eye_s1}),
		.stat     (f_stat),
		.unit     (f_unit),
		.side_out (f_side)
	);

	lav_norm #(
		.W      (PROD_W),
		.SIDE_W (SIDE_S_W)
	) u_norm_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.vec      (sr_s3),
		.side_in  ({fz_s3, f_s3, eye_s3}),
		.stat     (s_stat),
		.unit     (s_unit),
		.side_out (s_side)
	);

	// u = s x f, Q4.60 rounded half up to Q2.30
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ud     = $signed(sf_s4[2*i]) - $signed(sf_s4[2*i+1]);
			u_n[i] = UNIT_W'((ud + 64'sd536870912) >>> FRAC_UNIT);
		end
	end

	// rotation rows s, u, -f
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rot[0][c] = s_s5[c];
			rot[1][c] = u_s5[c];
			rot[2][c] = ~f_s5[c] + UNIT_W'(1);
		end
	end

	// rotation elements, Q2.30 rounded half up to Q16.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) begin
				rr = DIFF_W'($signed(rot[i][c])) + 33'sd8192;
				rq_n[i][c] = COORD_W'(rr >>> (FRAC_UNIT - 16));
			end
		end
	end

	// translation: -(R . eye) rounded to Q16.16 and saturated
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nd = -$signed(dot_s7[i]);
			rs = (nd + 66'sd536870912) >>> FRAC_UNIT;
			if (rs > 66'sd2147483647)
				tr_n[i] = 32'h7fff_ffff;
			else if (rs < -66'sd2147483648)
				tr_n[i] = 32'h8000_0000;
			else
				tr_n[i] = COORD_W'(rs);
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (dg_s7)
					mat_n[c][r] = (c == r) ? Q_ONE : '0;
				else if (c == 3)
					mat_n[c][r] = (r == 3) ? Q_ONE : tr_n[r];
				else if (r == 3)
					mat_n[c][r] = '0;
				else
					mat_n[c][r] = rq_s7[r][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= f_stat.valid;
			v_s3 <= v_s2;
			v_s4 <= s_stat.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				eye_s1[i] <= s_tdata[COORD_W*i +: COORD_W];
				up_s1[i]  <= s_tdata[COORD_W*(6+i) +: COORD_W];
				fd_s1[i]  <= DIFF_W'($signed(s_tdata[COORD_W*(3+i) +: COORD_W]))
					- DIFF_W'($signed(s_tdata[COORD_W*i +: COORD_W]));
			end

			// side vector products, pairs subtracted in the next stage
			fup_s2[0] <= PROD_W'($signed(f_unit[1])) * PROD_W'($signed(f_side[SIDE_F_W-1 -: COORD_W]));
			fup_s2[1] <= PROD_W'($signed(f_unit[2])) * PROD_W'($signed(f_side[4*COORD_W +: COORD_W]));
			fup_s2[2] <= PROD_W'($signed(f_unit[2])) * PROD_W'($signed(f_side[3*COORD_W +: COORD_W]));
			fup_s2[3] <= PROD_W'($signed(f_unit[0])) * PROD_W'($signed(f_side[SIDE_F_W-1 -: COORD_W]));
			fup_s2[4] <= PROD_W'($signed(f_unit[0])) * PROD_W'($signed(f_side[4*COORD_W +: COORD_W]));
			fup_s2[5] <= PROD_W'($signed(f_unit[1])) * PROD_W'($signed(f_side[3*COORD_W +: COORD_W]));
			f_s2   <= f_unit;
			eye_s2 <= f_side[3*COORD_W-1:0];
			fz_s2  <= f_stat.zero;

			for (int i = 0; i < 3; i++)
				sr_s3[i] <= PROD_W'($signed(fup_s2[2*i]) - $signed(fup_s2[2*i+1]));
			f_s3   <= f_s2;
			eye_s3 <= eye_s2;
			fz_s3  <= fz_s2;

			sf_s4[0] <= PROD_W'($signed(s_unit[1])) * PROD_W'($signed(s_side[6*COORD_W-1 -: UNIT_W]));
			sf_s4[1] <= PROD_W'($signed(s_unit[2])) * PROD_W'($signed(s_side[4*COORD_W +: UNIT_W]));
			sf_s4[2] <= PROD_W'($signed(s_unit[2])) * PROD_W'($signed(s_side[3*COORD_W +: UNIT_W]));
			sf_s4[3] <= PROD_W'($signed(s_unit[0])) * PROD_W'($signed(s_side[6*COORD_W-1 -: UNIT_W]));
			sf_s4[4] <= PROD_W'($signed(s_unit[0])) * PROD_W'($signed(s_side[4*COORD_W +: UNIT_W]));
			sf_s4[5] <= PROD_W'($signed(s_unit[1])) * PROD_W'($signed(s_side[3*COORD_W +: UNIT_W]));
			s_s4   <= s_unit;
			f_s4   <= s_side[6*COORD_W-1:3*COORD_W];
			eye_s4 <= s_side[3*COORD_W-1:0];
			dg_s4  <= s_side[SIDE_S_W-1] | s_stat.zero;

			u_s5   <= u_n;
			s_s5   <= s_s4;
			f_s5   <= f_s4;
			eye_s5 <= eye_s4;
			dg_s5  <= dg_s4;

			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++)
					prd_s6[i][c] <= PROD_W'($signed(rot[i][c])) * PROD_W'($signed(eye_s5[c]));
			end
			rq_s6 <= rq_n;
			dg_s6 <= dg_s5;

			for (int i = 0; i < 3; i++)
				dot_s7[i] <= DOT_W'($signed(prd_s6[i][0])) + DOT_W'($signed(prd_s6[i][1]))
					+ DOT_W'($signed(prd_s6[i][2]));
			rq_s7 <= rq_s6;
			dg_s7 <= dg_s6;

			mat_s8 <= mat_n;
			dg_s8  <= dg_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			col_q  <= 2'd0;
		end else begin
			if (load)
				full_q <= 1'b1;
			else if (m_take && col_q == COL_LAST)
				full_q <= 1'b0;
			if (m_take)
				col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			om_q  <= mat_s8;
			odg_q <= dg_s8;
		end
	end

	assign m_tdata = {6'b0, om_q[col_q][3], om_q[col_q][2], om_q[col_q][1],
		om_q[col_q][0], col_q};
	assign m_tuser = odg_q;
	assign m_tlast = (col_q == COL_LAST);

endmodule

// ----- sv/lav_norm.sv -----
// Pipelined 3-vector normalizer: scale, sum of squares, square root, three dividers.
module lav_norm
	import lav_pkg::*;
#(
	parameter int unsigned W      = 33,
	parameter int unsigned SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [2:0][W-1:0]      vec,
	input  logic [SIDE_W-1:0]      side_in,
	output lav_nstat_t             stat,
	output logic [2:0][UNIT_W-1:0] unit,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int unsigned P_W   = $clog2(W);
	localparam int unsigned SQ_W  = 2 * NORM_W;
	localparam int unsigned RAD_W = 2 * ROOT_W;
	localparam int unsigned REM_W = ROOT_W + 2;
	localparam int unsigned NUM_W = NORM_W + FRAC_UNIT + 1;

	typedef struct packed {
		logic [SIDE_W-1:0]      side;
		logic                   zero;
		logic [2:0]             sgn;
		logic [2:0][NORM_W-1:0] an;
	} pay_t;

	function automatic logic [P_W-1:0] msb_idx(input logic [W-1:0] v);
		logic [P_W-1:0] r;
		r = '0;
		for (int i = 0; i < W; i++) begin
			if (v[i]) r = P_W'(i);
		end
		return r;
	endfunction

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s7;
	logic [2:0][W-1:0]      mag_s1, mag_s2, mag_s3;
	logic [2:0]             sgn_s1, sgn_s2, sgn_s3;
	logic [SIDE_W-1:0]      side_s1, side_s2, side_s3;
	logic [W-1:0]           max_s2;
	logic [P_W-1:0]         msb_s3;
	logic                   zero_s3;
	pay_t                   pay_s4, pay_s5;
	logic [2:0][SQ_W-1:0]   sq_s5;

	// square root stages; index 0 holds the sum of squares
	logic                   rt_vld_s  [0:ROOT_W];
	logic [RAD_W-1:0]       rt_rad_s  [0:ROOT_W];
	logic [REM_W-1:0]       rt_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]      rt_root_s [0:ROOT_W];
	pay_t                   rt_pay_s  [0:ROOT_W];
	logic [REM_W+1:0]       rt_try    [0:ROOT_W-1];
	logic [REM_W+1:0]       rt_trial  [0:ROOT_W-1];
	logic                   rt_ge     [0:ROOT_W-1];

	// divider stages; index 0 holds the numerators
	logic                   dv_vld_s [0:ROOT_W];
	logic [ROOT_W-1:0]      dv_len_s [0:ROOT_W];
	logic [2:0][ROOT_W-1:0] dv_rem_s [0:ROOT_W];
	logic [2:0][ROOT_W-1:0] dv_num_s [0:ROOT_W];
	logic [2:0][ROOT_W-1:0] dv_q_s   [0:ROOT_W];
	pay_t                   dv_pay_s [0:ROOT_W];
	logic [2:0][ROOT_W:0]   dv_try   [0:ROOT_W-1];
	logic [2:0]             dv_ge    [0:ROOT_W-1];

	logic [W-1:0]           m01, mx;
	logic [2:0][NORM_W-1:0] an;
	logic [2:0][NUM_W-1:0]  nm;
	logic [2:0][UNIT_W-1:0] un;
	logic [UNIT_W-1:0]      qc;

	logic                   zero_s7;
	logic [2:0][UNIT_W-1:0] unit_s7;
	logic [SIDE_W-1:0]      side_s7;

	always_comb begin
		m01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		mx  = (m01 > mag_s1[2]) ? m01 : mag_s1[2];
	end

	// largest magnitude lands in [2^30, 2^31)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (msb_s3 > P_W'(FRAC_UNIT))
				an[i] = NORM_W'(mag_s3[i] >> (msb_s3 - P_W'(FRAC_UNIT)));
			else
				an[i] = NORM_W'(mag_s3[i] << (P_W'(FRAC_UNIT) - msb_s3));
		end
	end

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			rt_try[k]   = {rt_rem_s[k], rt_rad_s[k][RAD_W-1 -: 2]};
			rt_trial[k] = (REM_W + 2)'({rt_root_s[k], 2'b01});
			rt_ge[k]    = rt_try[k] >= rt_trial[k];
		end
	end

	// a * 2^30 + len / 2, rounded quotient
	always_comb begin
		for (int i = 0; i < 3; i++)
			nm[i] = (NUM_W'(rt_pay_s[ROOT_W].an[i]) << FRAC_UNIT)
				+ NUM_W'(rt_root_s[ROOT_W] >> 1);
	end

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			for (int i = 0; i < 3; i++) begin
				dv_try[k][i] = {dv_rem_s[k][i], dv_num_s[k][i][ROOT_W-1]};
				dv_ge[k][i]  = dv_try[k][i] >= {1'b0, dv_len_s[k]};
			end
		end
	end

	always_comb begin
		qc = '0;
		for (int i = 0; i < 3; i++) begin
			qc = (dv_q_s[ROOT_W][i] > UNIT_ONE) ? UNIT_ONE : dv_q_s[ROOT_W][i];
			if (dv_pay_s[ROOT_W].zero)
				un[i] = '0;
			else if (dv_pay_s[ROOT_W].sgn[i])
				un[i] = ~qc + UNIT_W'(1);
			else
				un[i] = qc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++) begin
				rt_vld_s[k] <= 1'b0;
				dv_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			rt_vld_s[0] <= v_s5;
			dv_vld_s[0] <= rt_vld_s[ROOT_W];
			for (int k = 0; k < ROOT_W; k++) begin
				rt_vld_s[k+1] <= rt_vld_s[k];
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
			v_s7 <= dv_vld_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sgn_s1[i] <= vec[i][W-1];
				mag_s1[i] <= vec[i][W-1] ? (~vec[i] + W'(1)) : vec[i];
			end
			side_s1 <= side_in;

			mag_s2  <= mag_s1;
			sgn_s2  <= sgn_s1;
			side_s2 <= side_s1;
			max_s2  <= mx;

			mag_s3  <= mag_s2;
			sgn_s3  <= sgn_s2;
			side_s3 <= side_s2;
			msb_s3  <= msb_idx(max_s2);
			zero_s3 <= (max_s2 == '0);

			pay_s4.side <= side_s3;
			pay_s4.zero <= zero_s3;
			pay_s4.sgn  <= sgn_s3;
			pay_s4.an   <= an;

			pay_s5 <= pay_s4;
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= SQ_W'(pay_s4.an[i]) * SQ_W'(pay_s4.an[i]);

			rt_rad_s[0]  <= RAD_W'(sq_s5[0]) + RAD_W'(sq_s5[1]) + RAD_W'(sq_s5[2]);
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			rt_pay_s[0]  <= pay_s5;
			for (int k = 0; k < ROOT_W; k++) begin
				rt_rad_s[k+1]  <= rt_rad_s[k] << 2;
				rt_rem_s[k+1]  <= rt_ge[k] ? REM_W'(rt_try[k] - rt_trial[k])
					: REM_W'(rt_try[k]);
				rt_root_s[k+1] <= {rt_root_s[k][ROOT_W-2:0], rt_ge[k]};
				rt_pay_s[k+1]  <= rt_pay_s[k];
			end

			dv_len_s[0] <= rt_root_s[ROOT_W];
			dv_pay_s[0] <= rt_pay_s[ROOT_W];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= ROOT_W'(nm[i] >> ROOT_W);
				dv_num_s[0][i] <= nm[i][ROOT_W-1:0];
				dv_q_s[0][i]   <= '0;
			end
			for (int k = 0; k < ROOT_W; k++) begin
				dv_len_s[k+1] <= dv_len_s[k];
				dv_pay_s[k+1] <= dv_pay_s[k];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k+1][i] <= dv_ge[k][i]
						? ROOT_W'(dv_try[k][i] - {1'b0, dv_len_s[k]})
						: dv_try[k][i][ROOT_W-1:0];
					dv_num_s[k+1][i] <= dv_num_s[k][i] << 1;
					dv_q_s[k+1][i]   <= {dv_q_s[k][i][ROOT_W-2:0], dv_ge[k][i]};
				end
			end

			zero_s7 <= dv_pay_s[ROOT_W].zero;
			unit_s7 <= un;
			side_s7 <= dv_pay_s[ROOT_W].side;
		end
	end

	always_comb begin
		stat.valid = v_s7;
		stat.zero  = zero_s7;
	end
	assign unit     = unit_s7;
	assign side_out = side_s7;

endmodule

// ----- tb/look_at_view_matrix_tb.sv -----
// Self-checking testbench for the look-at view matrix block.
module look_at_view_matrix_tb;
	import lav_pkg::*;

	localparam logic [31:0] CMAX = 32'h7fff_ffff;
	localparam logic [31:0] CMIN = 32'h8000_0000;
	localparam logic [31:0] CZERO = 32'h0;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] r0;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
		logic        degen;
		logic        last;
	} column_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [287:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	column_t col_q[$];
	logic [287:0] dir_data[$];
	bit dir_ident[$];
	int mismatches = 0;
	int items_sent = 0;
	int cols_seen = 0;
	int degen_seen = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_on = 0;
	int hold_cnt = 0;

	look_at_view_matrix u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("look_at_view_matrix test failed");
		$finish;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit vector in Q2.30, 0 on a zero-length input
	function automatic bit unit_vec(input longint v0, v1, v2, output longint o0, o1, o2);
		longint v[3];
		longint o[3];
		longint unsigned a[3];
		longint unsigned m, sum, len, n;
		int p;
		v[0] = v0; v[1] = v1; v[2] = v2;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
			if (a[i] > m) m = a[i];
		end
		o0 = 0; o1 = 0; o2 = 0;
		if (m == 0) return 0;
		p = 0;
		while (p < 63 && (m >> (p + 1)) != 0) p++;
		for (int i = 0; i < 3; i++) begin
			if (p > 30) a[i] >>= (p - 30);
			else a[i] <<= (30 - p);
			sum += a[i] * a[i];
		end
		len = int_sqrt(sum);
		if (len == 0) return 0;
		for (int i = 0; i < 3; i++) begin
			n = ((a[i] << 30) + len / 2) / len;
			if (n > 64'h4000_0000) n = 64'h4000_0000;
			o[i] = v[i] < 0 ? -longint'(n) : longint'(n);
		end
		o0 = o[0]; o1 = o[1]; o2 = o[2];
		return 1;
	endfunction

	function automatic longint round_up_shift(input longint v, input int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	function automatic void push_identity();
		column_t c;
		for (int k = 0; k < 4; k++) begin
			c.idx = k[1:0];
			c.r0 = (k == 0) ? Q_ONE : CZERO;
			c.r1 = (k == 1) ? Q_ONE : CZERO;
			c.r2 = (k == 2) ? Q_ONE : CZERO;
			c.r3 = (k == 3) ? Q_ONE : CZERO;
			c.degen = 1'b1;
			c.last = (k[1:0] == COL_LAST);
			col_q.push_back(c);
		end
	endfunction

	// queues the four view-matrix columns for one eye/center/up item
	function automatic void predict_view(input logic [287:0] d);
		longint eye[3], up[3], fd[3], f[3], sr[3], s[3], u[3];
		longint rot[3][3];
		longint e[4][4];
		longint dot;
		column_t c;
		bit ok;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'($signed(d[32*i +: 32]));
			fd[i] = longint'($signed(d[32*(3+i) +: 32])) - eye[i];
			up[i] = longint'($signed(d[32*(6+i) +: 32]));
		end
		ok = unit_vec(fd[0], fd[1], fd[2], f[0], f[1], f[2]);
		if (ok) begin
			sr[0] = f[1] * up[2] - f[2] * up[1];
			sr[1] = f[2] * up[0] - f[0] * up[2];
			sr[2] = f[0] * up[1] - f[1] * up[0];
			ok = unit_vec(sr[0], sr[1], sr[2], s[0], s[1], s[2]);
		end
		if (!ok) begin
			push_identity();
			return;
		end
		u[0] = round_up_shift(s[1] * f[2] - s[2] * f[1], 30);
		u[1] = round_up_shift(s[2] * f[0] - s[0] * f[2], 30);
		u[2] = round_up_shift(s[0] * f[1] - s[1] * f[0], 30);
		for (int k = 0; k < 3; k++) begin
			rot[0][k] = s[k];
			rot[1][k] = u[k];
			rot[2][k] = -f[k];
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) e[k][i] = round_up_shift(rot[i][k], 14);
			e[k][3] = 0;
		end
		for (int i = 0; i < 3; i++) begin
			dot = rot[i][0] * eye[0] + rot[i][1] * eye[1] + rot[i][2] * eye[2];
			e[3][i] = clip32(round_up_shift(-dot, 30));
		end
		e[3][3] = 65536;
		for (int k = 0; k < 4; k++) begin
			c.idx = k[1:0];
			c.r0 = e[k][0][31:0];
			c.r1 = e[k][1][31:0];
			c.r2 = e[k][2][31:0];
			c.r3 = e[k][3][31:0];
			c.degen = 1'b0;
			c.last = (k[1:0] == COL_LAST);
			col_q.push_back(c);
		end
	endfunction

	function automatic logic [287:0] pack9(input logic [31:0] ex, ey, ez, cx, cy, cz,
			ux, uy, uz);
		return {uz, uy, ux, cz, cy, cx, ez, ey, ex};
	endfunction

	task automatic add_row(input logic [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz,
			input bit ident);
		dir_data.push_back(pack9(ex, ey, ez, cx, cy, cz, ux, uy, uz));
		dir_ident.push_back(ident);
	endtask

	// offers one item; ident selects the hand-typed identity expectation
	task automatic send_item(input logic [287:0] d, input bit ident);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (ident) push_identity();
		else predict_view(d);
		items_sent++;
	endtask

	function automatic logic [31:0] rand_small();
		return $urandom_range(13107200) - 32'd6553600;  // about +-100.0
	endfunction

	function automatic logic [287:0] rand_item();
		logic [31:0] v[9];
		logic [31:0] dd[3];
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 9; i++) v[i] = (mode < 5) ? $urandom() : rand_small();
		if (mode == 0) begin
			// center on the eye
			v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
		end else if (mode == 1) begin
			// up exactly parallel to the view direction
			for (int i = 0; i < 3; i++) begin
				dd[i] = $urandom_range(2000) - 1000;
				v[i] = rand_small();
				v[3+i] = v[i] + dd[i];
				v[6+i] = dd[i] * ($urandom_range(5) + 1);
			end
		end
		return {v[8], v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		while (col_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) send_item(rand_item(), 1'b0);
		drain();
	endtask

	// output side: ready pattern, with one long hold-off counted here
	always @(posedge clk) begin
		if (hold_on && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// column checker
	always @(posedge clk) begin
		column_t want;
		if (arst_n && m_tvalid && m_tready) begin
			cols_seen++;
			if (m_tuser) degen_seen++;
			if (col_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected column %0d", m_tdata[1:0]);
			end else begin
				want = col_q.pop_front();
				if (want.idx !== m_tdata[1:0] || want.r0 !== m_tdata[33:2] ||
						want.r1 !== m_tdata[65:34] || want.r2 !== m_tdata[97:66] ||
						want.r3 !== m_tdata[129:98] || want.degen !== m_tuser ||
						want.last !== m_tlast) begin
					mismatches++;
					if (mismatches <= 10)
						$display("column mismatch: exp %0d %h %h %h %h dg%b l%b, got %0d %h %h %h %h dg%b l%b",
							want.idx, want.r0, want.r1, want.r2, want.r3, want.degen,
							want.last, m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
							m_tdata[97:66], m_tdata[129:98], m_tuser, m_tlast);
				end
			end
		end
	end

	initial begin
		// center equals eye: identity
		add_row(0, 0, 0, 0, 0, 0, 0, Q_ONE, 0, 1);
		add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1);
		add_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1);
		// zero up vector
		add_row(0, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 1);
		// up parallel to the view direction
		add_row(0, 0, 0, 0, 0, -Q_ONE, 0, 0, 5 * Q_ONE, 1);
		add_row(Q_ONE, Q_ONE, Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, CMAX, CMAX, CMAX, 0);
		// plain camera on the z axis
		add_row(0, 0, 5 * Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0);
		add_row(0, 0, 0, 0, 0, -Q_ONE, 0, Q_ONE, 0, 0);
		// widest forward differences
		add_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, Q_ONE, 0, 0);
		add_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, 0);
		// translation saturation along the diagonal
		add_row(CMAX, CMAX, CMAX, CMAX - Q_ONE, CMAX - Q_ONE, CMAX - Q_ONE, 0, Q_ONE, 0, 0);
		add_row(CMIN, CMIN, CMIN, CMIN + Q_ONE, CMIN + Q_ONE, CMIN + Q_ONE, 0, Q_ONE, 0, 0);
		// extreme up values, smallest steps
		add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
		add_row(0, 0, 0, 0, 32'hffff_ffff, 0, CMAX, CMIN, CMAX, 0);
		add_row(CMAX, 0, CMIN, 0, CMAX, 0, CMIN, 32'hffff_ffff, 1, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < dir_data.size(); i++) send_item(dir_data[i], dir_ident[i]);
		drain();

		run_phase(20, 0, 0);
		run_phase(20, 81, 0);
		run_phase(20, 0, 81);
		run_phase(20, 28, 28);

		// long output hold-off with the input pushed flat out, fills the pipeline
		idle_pct = 0;
		stall_pct = 0;
		hold_on = 1;
		for (int i = 0; i < 160; i++) send_item(rand_item(), 1'b0);
		drain();

		$display("sent %0d items, checked %0d columns (%0d degenerate) over idle, stall",
			items_sent, cols_seen, degen_seen);
		$display("and full-pipeline backpressure phases; %0d mismatches", mismatches);
		if (mismatches == 0 && col_q.size() == 0) begin
			$display("look_at_view_matrix test passed");
		end else begin
			$display("look_at_view_matrix test failed");
		end
		$finish;
	end

endmodule
